### hdl/fpc_pkg.sv
package fpc_pkg;

   localparam int FRAME_BYTES = 34;
   localparam int POS_W = $clog2(FRAME_BYTES);

   localparam logic [POS_W-1:0] TYPE_FIRST = POS_W'(12);
   localparam logic [POS_W-1:0] TYPE_LAST  = POS_W'(13);
   localparam logic [POS_W-1:0] SRC_FIRST  = POS_W'(26);
   localparam logic [POS_W-1:0] SRC_LAST   = POS_W'(29);
   localparam logic [POS_W-1:0] DST_FIRST  = POS_W'(30);
   localparam logic [POS_W-1:0] DST_LAST   = POS_W'(33);
   localparam logic [POS_W-1:0] FRAME_LAST = POS_W'(FRAME_BYTES - 1);

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [31:0] HITS_MAX = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      ST_NOT_IPV4 = 2'd0,
      ST_NEW      = 2'd1,
      ST_REPEAT   = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   // lookup token that walks the cell row
   typedef struct packed {
      logic        valid;
      logic        live;     // still searching for a cell
      status_type  status;
      logic [31:0] hits;
      logic [31:0] src;
      logic [31:0] dst;
   } token_type;

endpackage

### hdl/fpc_header_capture.sv
module fpc_header_capture (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               byte_accept,
   input  logic [7:0]         frame_byte,
   output fpc_pkg::token_type tok_o
);
   import fpc_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      type_ff, type_in;
   logic [31:0]      src_ff, src_in;
   logic [31:0]      dst_ff, dst_in;
   token_type        tok_ff, tok_in;

   always_comb begin
      pos_in  = pos_ff;
      type_in = type_ff;
      src_in  = src_ff;
      dst_in  = dst_ff;
      tok_in  = '0;
      if (byte_accept) begin
         if (pos_ff >= TYPE_FIRST && pos_ff <= TYPE_LAST) begin
            type_in = {type_ff[7:0], frame_byte};
         end
         if (pos_ff >= SRC_FIRST && pos_ff <= SRC_LAST) begin
            src_in = {src_ff[23:0], frame_byte};
         end
         if (pos_ff >= DST_FIRST && pos_ff <= DST_LAST) begin
            dst_in = {dst_ff[23:0], frame_byte};
         end
         if (pos_ff == FRAME_LAST) begin
            pos_in       = '0;
            tok_in.valid = 1'b1;
            tok_in.live  = (type_in == ETHERTYPE_IPV4);
            tok_in.status = ST_NOT_IPV4;
            tok_in.hits  = '0;
            tok_in.src   = src_in;
            tok_in.dst   = dst_in;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         type_ff      <= '0;
         src_ff       <= '0;
         dst_ff       <= '0;
         tok_ff.valid <= 1'b0;
      end else if (en) begin
         pos_ff  <= pos_in;
         type_ff <= type_in;
         src_ff  <= src_in;
         dst_ff  <= dst_in;
         tok_ff  <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule

### hdl/fpc_flow_cell.sv
module fpc_flow_cell #(
   parameter int INDEX = 0,
   parameter int IDX_W = 6,
   parameter int CNT_W = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  fpc_pkg::token_type tok_i,
   input  logic [IDX_W-1:0]   idx_i,
   input  logic [CNT_W-1:0]   cnt_i,
   output fpc_pkg::token_type tok_o,
   output logic [IDX_W-1:0]   idx_o,
   output logic [CNT_W-1:0]   cnt_o
);
   import fpc_pkg::*;

   logic              used_ff, used_in;
   logic [63:0]       key_ff, key_in;
   logic [31:0]       hits_ff, hits_in;
   token_type         tok_ff, tok_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              match, claim;

   assign match = used_ff && tok_i.valid && tok_i.live && (key_ff == {tok_i.src, tok_i.dst});
   assign claim = !used_ff && tok_i.valid && tok_i.live;

   always_comb begin
      used_in = used_ff;
      key_in  = key_ff;
      hits_in = hits_ff;
      tok_in  = tok_i;
      idx_in  = idx_i;
      cnt_in  = cnt_i + CNT_W'(used_ff || claim);
      if (match) begin
         hits_in       = (hits_ff == HITS_MAX) ? hits_ff : hits_ff + 32'd1;
         tok_in.live   = 1'b0;
         tok_in.status = ST_REPEAT;
         tok_in.hits   = hits_in;
         idx_in        = IDX_W'(INDEX);
      end else if (claim) begin
         used_in       = 1'b1;
         key_in        = {tok_i.src, tok_i.dst};
         hits_in       = 32'd1;
         tok_in.live   = 1'b0;
         tok_in.status = ST_NEW;
         tok_in.hits   = 32'd1;
         idx_in        = IDX_W'(INDEX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else if (en) begin
         used_ff <= used_in;
         tok_ff  <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         key_ff  <= key_in;
         hits_ff <= hits_in;
         idx_ff  <= idx_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign tok_o = tok_ff;
   assign idx_o = idx_ff;
   assign cnt_o = cnt_ff;

endmodule

### hdl/ipv4_flow_pair_counter_unit.sv
// channel  dir  fields (tdata, low bit up)
// req      in   frame_byte[7:0]
// rsp      out  status[1:0], entry_index, hit_count[31:0], distinct_flows,
//               source_address[31:0], dest_address[31:0], zero pad to bytes
//
// One header byte is taken per cycle unless rsp stalls. A frame's result
// is registered in the capture stage, then in each flow cell as the lookup
// token walks the row, then in rsp; lookups of later frames follow in
// the same row. A stalled rsp word freezes the whole block, req included.
// Reset clears the byte position, the header captures and the cell use bits.
module ipv4_flow_pair_counter_unit #(
   parameter int TABLE_ENTRIES = 64,
   localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
   localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1),
   localparam int RAW_W  = 2 + IDX_W + 32 + CNT_W + 64,
   localparam int DATA_W = ((RAW_W + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // frame_byte[7:0]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata    // status, entry_index, hit_count,
                                          // distinct_flows, source_address,
                                          // dest_address
);
   import fpc_pkg::*;

   logic              en;
   token_type         tok [0:TABLE_ENTRIES];
   logic [IDX_W-1:0]  idx [0:TABLE_ENTRIES];
   logic [CNT_W-1:0]  cnt [0:TABLE_ENTRIES];

   logic              rsp_valid_ff, rsp_valid_in;
   logic [RAW_W-1:0]  rsp_data_ff, rsp_data_in;
   token_type         last_tok;
   status_type        last_status;
   logic [IDX_W-1:0]  last_idx;
   logic [31:0]       last_hits;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   fpc_header_capture u_capture (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .byte_accept (req_tvalid && en),
      .frame_byte  (req_tdata),
      .tok_o       (tok[0])
   );

   assign idx[0] = '0;
   assign cnt[0] = '0;

   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      fpc_flow_cell #(
         .INDEX (g),
         .IDX_W (IDX_W),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .tok_i (tok[g]),
         .idx_i (idx[g]),
         .cnt_i (cnt[g]),
         .tok_o (tok[g+1]),
         .idx_o (idx[g+1]),
         .cnt_o (cnt[g+1])
      );
   end

   // a token still searching at the end of the row found no free cell
   always_comb begin
      last_tok    = tok[TABLE_ENTRIES];
      last_status = last_tok.status;
      last_idx    = idx[TABLE_ENTRIES];
      last_hits   = last_tok.hits;
      if (last_tok.live) begin
         last_status = ST_FULL;
         last_idx    = '0;
         last_hits   = '0;
      end
      rsp_valid_in = last_tok.valid;
      rsp_data_in  = {last_tok.dst, last_tok.src, cnt[TABLE_ENTRIES], last_hits,
                      last_idx, last_status};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'(rsp_data_ff);

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

import fpc_pkg::*;

class flow_tracker #(int ENTRIES = 64, int IDX_W = 6, int CNT_W = 7);
   localparam int DATA_W = ((2 + IDX_W + 32 + CNT_W + 64 + 7) / 8) * 8;

   typedef struct {
      status_type          status;
      logic [IDX_W-1:0]    entry;
      logic [31:0]         hits;
      logic [CNT_W-1:0]    flows;
      logic [31:0]         src;
      logic [31:0]         dst;
   } report_type;

   report_type       pending[$];
   logic [POS_W-1:0] pos_in_frame;
   logic [15:0]      ethertype_shift;
   logic [31:0]      src_shift;
   logic [31:0]      dst_shift;
   logic [63:0]      pair_keys[ENTRIES];
   logic [31:0]      pair_counts[ENTRIES];
   int               pairs_held;
   int               mismatches;
   int               status_seen[4];

   function new();
      pos_in_frame    = '0;
      ethertype_shift = '0;
      src_shift       = '0;
      dst_shift       = '0;
      pairs_held      = 0;
      mismatches      = 0;
      foreach (status_seen[s]) status_seen[s] = 0;
   endfunction

   function void note_header_byte(logic [7:0] value);
      report_type  rep;
      logic [63:0] key;
      int          slot;
      if (pos_in_frame >= TYPE_FIRST && pos_in_frame <= TYPE_LAST)
         ethertype_shift = {ethertype_shift[7:0], value};
      if (pos_in_frame >= SRC_FIRST && pos_in_frame <= SRC_LAST)
         src_shift = {src_shift[23:0], value};
      if (pos_in_frame >= DST_FIRST && pos_in_frame <= DST_LAST)
         dst_shift = {dst_shift[23:0], value};
      if (pos_in_frame != FRAME_LAST) begin
         pos_in_frame++;
         return;
      end
      pos_in_frame = '0;
      rep.entry = '0;
      rep.hits  = '0;
      rep.src   = src_shift;
      rep.dst   = dst_shift;
      key  = {src_shift, dst_shift};
      slot = -1;
      if (ethertype_shift != ETHERTYPE_IPV4) begin
         rep.status = ST_NOT_IPV4;
      end else begin
         for (int i = 0; i < pairs_held; i++)
            if (slot < 0 && pair_keys[i] == key) slot = i;
         if (slot >= 0) begin
            if (pair_counts[slot] != HITS_MAX) pair_counts[slot]++;
            rep.status = ST_REPEAT;
            rep.entry  = IDX_W'(slot);
            rep.hits   = pair_counts[slot];
         end else if (pairs_held < ENTRIES) begin
            pair_keys[pairs_held]   = key;
            pair_counts[pairs_held] = 32'd1;
            rep.status = ST_NEW;
            rep.entry  = IDX_W'(pairs_held);
            rep.hits   = 32'd1;
            pairs_held++;
         end else begin
            rep.status = ST_FULL;
         end
      end
      rep.flows = CNT_W'(pairs_held);
      status_seen[rep.status]++;
      pending.push_back(rep);
   endfunction

   function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   function void check_report(logic [DATA_W-1:0] word);
      report_type rep;
      if (pending.size() == 0) begin
         $error("rsp word %0h with no frame outstanding", word);
         mismatches++;
         return;
      end
      rep = pending.pop_front();
      compare_field("status", 32'(rep.status), 32'(word[1:0]));
      compare_field("entry_index", 32'(rep.entry), 32'(word[2 +: IDX_W]));
      compare_field("hit_count", rep.hits, word[2 + IDX_W +: 32]);
      compare_field("distinct_flows", 32'(rep.flows), 32'(word[34 + IDX_W +: CNT_W]));
      compare_field("source_address", rep.src, word[34 + IDX_W + CNT_W +: 32]);
      compare_field("dest_address", rep.dst, word[66 + IDX_W + CNT_W +: 32]);
   endfunction
endclass

module testbench;
   localparam int TABLE_SIZE     = 64;
   localparam int IDX_W          = 6;
   localparam int CNT_W          = 7;
   localparam int DATA_W         = 112;
   localparam int WATCHDOG_LIMIT = 4000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;

   int          send_gap_pct = 0;
   int          accept_stall_pct = 0;
   int          quiet_cycles = 0;
   int          bytes_sent = 0;
   int          gap_by_phase[4] = '{0, 49, 0, 36};
   int          stall_by_phase[4] = '{0, 0, 49, 36};
   logic [63:0] used_pairs[$];

   flow_tracker #(TABLE_SIZE, IDX_W, CNT_W) tracker;

   ipv4_flow_pair_counter_unit #(.TABLE_ENTRIES(TABLE_SIZE)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= accept_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) tracker.check_report(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   task automatic push_byte(input logic [7:0] value);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      tracker.note_header_byte(value);
      bytes_sent++;
   endtask

   // filler < 0: random bytes outside the ethertype and address fields
   task automatic send_flow_frame(input logic [15:0] ethertype, input logic [31:0] src,
                                  input logic [31:0] dst, input int filler);
      logic [7:0] value;
      for (int i = 0; i < FRAME_BYTES; i++) begin
         value = (filler < 0) ? 8'($urandom) : 8'(filler);
         if (i == int'(TYPE_FIRST))
            value = ethertype[15:8];
         else if (i == int'(TYPE_LAST))
            value = ethertype[7:0];
         else if (i >= int'(SRC_FIRST) && i <= int'(SRC_LAST))
            value = src[8 * (int'(SRC_LAST) - i) +: 8];
         else if (i >= int'(DST_FIRST) && i <= int'(DST_LAST))
            value = dst[8 * (int'(DST_LAST) - i) +: 8];
         push_byte(value);
      end
   endtask

   task automatic drain_reports();
      while (tracker.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      int          pick;
      int          new_pct;
      int          random_frames;
      int          phase;
      logic [63:0] pair;
      logic [63:0] base;
      tracker = new();
      random_frames = 0;
      phase = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_flow_frame(16'h0000, 32'h0, 32'h0, 0);
      send_flow_frame(16'hFFFF, '1, '1, 255);
      send_flow_frame(ETHERTYPE_IPV4, 32'h0, 32'h0, -1);
      send_flow_frame(ETHERTYPE_IPV4, '1, '1, 255);
      send_flow_frame(ETHERTYPE_IPV4, 32'h0, 32'h0, 0);
      send_flow_frame(ETHERTYPE_IPV4, 32'h0, '1, -1);
      send_flow_frame(16'h0008, '1, 32'h0, -1);
      used_pairs.push_back({32'h0, 32'h0});
      used_pairs.push_back({32'hFFFF_FFFF, 32'hFFFF_FFFF});
      used_pairs.push_back({32'h0, 32'hFFFF_FFFF});
      used_pairs.push_back({32'hFFFF_FFFF, 32'h0});
      req_tvalid <= 1'b0;
      drain_reports();

      // one group of frames per idling phase
      while (random_frames < 40) begin
         send_gap_pct     = gap_by_phase[phase % 4];
         accept_stall_pct = stall_by_phase[phase % 4];
         for (int n = 0; n < 10; n++) begin
            pick    = $urandom_range(99);
            new_pct = (tracker.pairs_held < TABLE_SIZE) ? 70 : 35;
            pair    = used_pairs[$urandom_range(used_pairs.size() - 1)];
            if (pick < 8) begin
               send_flow_frame(16'($urandom), $urandom, $urandom, -1);
            end else if (pick < 16) begin
               send_flow_frame(ETHERTYPE_IPV4 ^ (16'h1 << $urandom_range(15)),
                               pair[63:32], pair[31:0], -1);
            end else if (pick < 100 - new_pct) begin
               send_flow_frame(ETHERTYPE_IPV4, pair[63:32], pair[31:0], -1);
            end else begin
               pick = $urandom_range(99);
               base = pair;
               if (pick < 20)
                  pair = {base[63:32], 32'($urandom)};
               else if (pick < 30)
                  pair = {base[31:0], base[63:32]};
               else
                  pair = {32'($urandom), 32'($urandom)};
               used_pairs.push_back(pair);
               send_flow_frame(ETHERTYPE_IPV4, pair[63:32], pair[31:0], -1);
            end
            random_frames++;
         end
         req_tvalid <= 1'b0;
         drain_reports();
         phase++;
      end

      req_tvalid <= 1'b0;
      accept_stall_pct = 0;
      drain_reports();
      repeat (TABLE_SIZE + 16) @(posedge clock);

      $display("Sent %0d header bytes in %0d frames over %0d idling phases.",
               bytes_sent, bytes_sent / FRAME_BYTES, phase);
      $display("Reports: %0d new, %0d repeat, %0d table full, %0d non-IPv4; %0d flows held.",
               tracker.status_seen[ST_NEW], tracker.status_seen[ST_REPEAT],
               tracker.status_seen[ST_FULL], tracker.status_seen[ST_NOT_IPV4],
               tracker.pairs_held);
      if (tracker.mismatches == 0 && tracker.pending.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule

### files.f
hdl/fpc_pkg.sv
hdl/fpc_header_capture.sv
hdl/fpc_flow_cell.sv
hdl/ipv4_flow_pair_counter_unit.sv
dv/testbench.sv
